/* rtl/ll1ep_pkg.sv */
// Shared types, symbol codes and grammar tables for the LL(1) expression parser.
// Used by ll1ep_rule and ll1_expression_parser; no dependencies.
package ll1ep_pkg;

    // Terminal and nonterminal symbol codes (4-bit stack entries)
    localparam logic [3:0] SYM_I   = 4'd0;
    localparam logic [3:0] SYM_N   = 4'd1;
    localparam logic [3:0] SYM_ADD = 4'd2;
    localparam logic [3:0] SYM_SUB = 4'd3;
    localparam logic [3:0] SYM_MUL = 4'd4;
    localparam logic [3:0] SYM_DIV = 4'd5;
    localparam logic [3:0] SYM_LP  = 4'd6;
    localparam logic [3:0] SYM_RP  = 4'd7;
    localparam logic [3:0] SYM_END = 4'd8;
    localparam logic [3:0] SYM_E   = 4'd9;
    localparam logic [3:0] SYM_A   = 4'd10;
    localparam logic [3:0] SYM_T   = 4'd11;
    localparam logic [3:0] SYM_B   = 4'd12;
    localparam logic [3:0] SYM_F   = 4'd13;
    localparam logic [3:0] CLS_BAD = 4'd15;

    // Production indexes in grammar order
    localparam logic [3:0] P_E_TA   = 4'd0;
    localparam logic [3:0] P_A_ADD  = 4'd1;
    localparam logic [3:0] P_A_SUB  = 4'd2;
    localparam logic [3:0] P_A_EPS  = 4'd3;
    localparam logic [3:0] P_T_FB   = 4'd4;
    localparam logic [3:0] P_B_MUL  = 4'd5;
    localparam logic [3:0] P_B_DIV  = 4'd6;
    localparam logic [3:0] P_B_EPS  = 4'd7;
    localparam logic [3:0] P_F_ID   = 4'd8;
    localparam logic [3:0] P_F_PAR  = 4'd9;
    localparam logic [3:0] P_F_NUM  = 4'd10;
    localparam logic [3:0] NO_PROD  = 4'd15;

    typedef enum logic [2:0] {
        EV_PROD     = 3'd0,
        EV_MATCH    = 3'd1,
        EV_ACCEPT   = 3'd2,
        EV_SYNTAX   = 3'd3,
        EV_ILLEGAL  = 3'd4,
        EV_OVERFLOW = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // Decision of one stack action, handed from the rule unit to the sequencer
    typedef struct packed {
        event_t     ev;
        logic [3:0] prod;
        logic [3:0] tcls;
        logic       stop;   // action ends the work on this word
        logic       pop;    // terminal on top is removed
        logic [1:0] len;    // symbols pushed by an expansion
        logic [3:0] sym0;   // push order: sym0 deepest
        logic [3:0] sym1;
        logic [3:0] sym2;
    } rule_t;

    // Map a character byte to its terminal class
    function automatic logic [3:0] classify(input logic [7:0] c);
        logic [3:0] r;
        r = CLS_BAD;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            r = SYM_I;
        else if (c >= 8'h30 && c <= 8'h39)
            r = SYM_N;
        else
        begin
            unique case (c)
                8'h2B:   r = SYM_ADD;
                8'h2D:   r = SYM_SUB;
                8'h2A:   r = SYM_MUL;
                8'h2F:   r = SYM_DIV;
                8'h28:   r = SYM_LP;
                8'h29:   r = SYM_RP;
                8'h24:   r = SYM_END;
                default: r = CLS_BAD;
            endcase
        end
        return r;
    endfunction

    // Predictive parse table: nonterminal on top versus lookahead class
    function automatic logic [3:0] parse_lookup(input logic [3:0] nt, input logic [3:0] cls);
        logic [3:0] p;
        p = NO_PROD;
        unique case (nt)
            SYM_E:
            begin
                unique case (cls) inside
                    SYM_I, SYM_N, SYM_LP: p = P_E_TA;
                    default:              p = NO_PROD;
                endcase
            end
            SYM_A:
            begin
                unique case (cls) inside
                    SYM_ADD:          p = P_A_ADD;
                    SYM_SUB:          p = P_A_SUB;
                    SYM_RP, SYM_END:  p = P_A_EPS;
                    default:          p = NO_PROD;
                endcase
            end
            SYM_T:
            begin
                unique case (cls) inside
                    SYM_I, SYM_N, SYM_LP: p = P_T_FB;
                    default:              p = NO_PROD;
                endcase
            end
            SYM_B:
            begin
                unique case (cls) inside
                    SYM_MUL:                          p = P_B_MUL;
                    SYM_DIV:                          p = P_B_DIV;
                    SYM_ADD, SYM_SUB, SYM_RP, SYM_END: p = P_B_EPS;
                    default:                          p = NO_PROD;
                endcase
            end
            SYM_F:
            begin
                unique case (cls)
                    SYM_I:   p = P_F_ID;
                    SYM_N:   p = P_F_NUM;
                    SYM_LP:  p = P_F_PAR;
                    default: p = NO_PROD;
                endcase
            end
            default: p = NO_PROD;
        endcase
        return p;
    endfunction

    // Right-hand side length of a production
    function automatic logic [1:0] rhs_len(input logic [3:0] p);
        logic [1:0] n;
        unique case (p) inside
            P_E_TA, P_T_FB:                      n = 2'd2;
            P_A_ADD, P_A_SUB, P_B_MUL, P_B_DIV,
            P_F_PAR:                             n = 2'd3;
            P_F_ID, P_F_NUM:                     n = 2'd1;
            default:                             n = 2'd0;
        endcase
        return n;
    endfunction

    // Right-hand side symbols in push order, packed {sym2, sym1, sym0}
    function automatic logic [11:0] rhs_push(input logic [3:0] p);
        logic [11:0] s;
        unique case (p)
            P_E_TA:  s = {4'd0, SYM_T, SYM_A};
            P_A_ADD: s = {SYM_ADD, SYM_T, SYM_A};
            P_A_SUB: s = {SYM_SUB, SYM_T, SYM_A};
            P_T_FB:  s = {4'd0, SYM_F, SYM_B};
            P_B_MUL: s = {SYM_MUL, SYM_F, SYM_B};
            P_B_DIV: s = {SYM_DIV, SYM_F, SYM_B};
            P_F_ID:  s = {4'd0, 4'd0, SYM_I};
            P_F_PAR: s = {SYM_LP, SYM_E, SYM_RP};
            P_F_NUM: s = {4'd0, 4'd0, SYM_N};
            default: s = 12'd0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/ll1ep_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the symbol stack below its top entry.
module ll1ep_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ll1ep_rule.sv */
// Shared decision unit: one stack action from top symbol, lookahead and depth.
// Depends on ll1ep_pkg for symbol codes, grammar tables and rule_t.
module ll1ep_rule #(
    parameter int STACK_DEPTH = 64
) (
    input  logic [3:0]                       tos,
    input  logic [3:0]                       cls,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] sp,
    output ll1ep_pkg::rule_t                 rule
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    logic [3:0]    prod;
    logic [1:0]    len;
    logic [11:0]   push;
    logic [SP_W:0] need;

    assign prod = ll1ep_pkg::parse_lookup(tos, cls);
    assign len  = ll1ep_pkg::rhs_len(prod);
    assign push = ll1ep_pkg::rhs_push(prod);
    // Entries in use after the expansion
    assign need = {1'b0, sp} - (SP_W+1)'(1) + (SP_W+1)'(len);

    // Pick the action in priority order
    always_comb
    begin
        rule      = '0;
        rule.ev   = ll1ep_pkg::EV_SYNTAX;
        rule.stop = 1'b1;
        rule.len  = len;
        rule.sym0 = push[3:0];
        rule.sym1 = push[7:4];
        rule.sym2 = push[11:8];
        if (sp == '0 || sp > SP_W'(STACK_DEPTH))
            rule.ev = ll1ep_pkg::EV_SYNTAX;
        else if (tos <= ll1ep_pkg::SYM_END)
        begin
            if (tos == cls)
            begin
                rule.pop  = 1'b1;
                rule.tcls = tos;
                rule.ev   = (tos == ll1ep_pkg::SYM_END) ? ll1ep_pkg::EV_ACCEPT
                                                        : ll1ep_pkg::EV_MATCH;
            end
        end
        else if (tos > ll1ep_pkg::SYM_F)
            rule.ev = ll1ep_pkg::EV_SYNTAX;
        else if (cls == ll1ep_pkg::CLS_BAD)
            rule.ev = ll1ep_pkg::EV_ILLEGAL;
        else if (prod == ll1ep_pkg::NO_PROD)
            rule.ev = ll1ep_pkg::EV_SYNTAX;
        else if (need > (SP_W+1)'(STACK_DEPTH))
            rule.ev = ll1ep_pkg::EV_OVERFLOW;
        else
        begin
            rule.ev   = ll1ep_pkg::EV_PROD;
            rule.prod = prod;
            rule.stop = 1'b0;
        end
    end

endmodule

/* rtl/ll1_expression_parser.sv */
// LL(1) expression parser: one character word in, up to four event words out.
// Each stack action passes through the shared rule unit; a pop or a third pushed symbol adds
// a stack RAM access in ST_READ or ST_WRITE, and a parsed word ends in ST_FINISH. A word is
// taken only in ST_IDLE, so a new word waits until the last one is done; a word that comes
// after the parse is done is dropped there, and ST_EVAL holds while the output stalls.
// Reset: stack holds end marker and E, pointer 2, no parse done; stack RAM needs no clearing.
module ll1_expression_parser #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] event_res, [6:3] production, [10:7] terminal_class
    output logic        m_tlast    // last
);

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    ll1ep_pkg::state_t state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [3:0]        tos_reg, tos_next;
    logic              done_reg, done_next;
    logic [3:0]        cls_reg, cls_next;
    logic              eos_reg, eos_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              end_reg, end_next;
    logic              rd_zero_reg, rd_zero_next;
    logic [3:0]        wsym_reg, wsym_next;
    logic [ADDR_W-1:0] waddr_reg, waddr_next;

    logic              out_valid_reg, out_valid_next;
    ll1ep_pkg::event_t out_ev_reg, out_ev_next;
    logic [3:0]        out_prod_reg, out_prod_next;
    logic [3:0]        out_tcls_reg, out_tcls_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;
    logic              out_free;

    ll1ep_pkg::rule_t  rule;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [3:0]        ram_wdata;
    logic              ram_re;
    logic [3:0]        ram_rdata;
    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;

    ll1ep_rule #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_rule (
        .tos  (tos_reg),
        .cls  (cls_reg),
        .sp   (sp_reg),
        .rule (rule)
    );

    ll1ep_ram #(
        .WIDTH(4),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (sp_m2[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign sp_m1    = sp_reg - SP_W'(1);
    assign sp_m2    = sp_reg - SP_W'(2);
    assign out_free = !out_valid_reg || m_tready;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ll1ep_pkg::ST_IDLE;
            sp_reg        <= SP_W'(2);
            tos_reg       <= ll1ep_pkg::SYM_E;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            tos_reg       <= tos_next;
            done_reg      <= done_next;
            cnt_reg       <= cnt_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cls_reg      <= cls_next;
        eos_reg      <= eos_next;
        rd_zero_reg  <= rd_zero_next;
        wsym_reg     <= wsym_next;
        waddr_reg    <= waddr_next;
        out_ev_reg   <= out_ev_next;
        out_prod_reg <= out_prod_next;
        out_tcls_reg <= out_tcls_next;
        out_last_reg <= out_last_next;
    end

    // Sequencer: one stack action per visit to the rule unit
    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        tos_next       = tos_reg;
        done_next      = done_reg;
        cls_next       = cls_reg;
        eos_next       = eos_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        rd_zero_next   = rd_zero_reg;
        wsym_next      = wsym_reg;
        waddr_next     = waddr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ev_next    = out_ev_reg;
        out_prod_next  = out_prod_reg;
        out_tcls_next  = out_tcls_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = sp_m1[ADDR_W-1:0];
        ram_wdata      = rule.sym0;
        ram_re         = 1'b0;
        s_tready       = (state_reg == ll1ep_pkg::ST_IDLE);

        unique case (state_reg)
            ll1ep_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    eos_next = s_tlast;
                    cls_next = s_tlast ? ll1ep_pkg::SYM_END : ll1ep_pkg::classify(s_tdata);
                    cnt_next = '0;
                    if (done_reg)
                    begin
                        // drop the word; an end word restarts the stack
                        if (s_tlast)
                        begin
                            sp_next   = SP_W'(2);
                            tos_next  = ll1ep_pkg::SYM_E;
                            done_next = 1'b0;
                        end
                    end
                    else
                        state_next = ll1ep_pkg::ST_EVAL;
                end
            end

            ll1ep_pkg::ST_EVAL:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_ev_next    = rule.ev;
                    out_prod_next  = rule.prod;
                    out_tcls_next  = rule.tcls;
                    out_last_next  = rule.stop || (cnt_reg == 2'd3);
                    if (rule.stop)
                    begin
                        if (rule.ev != ll1ep_pkg::EV_MATCH)
                            done_next = 1'b1;
                        if (rule.pop)
                            sp_next = sp_m1;
                        if (rule.ev == ll1ep_pkg::EV_MATCH)
                        begin
                            // fetch the entry below the matched terminal
                            ram_re       = 1'b1;
                            rd_zero_next = (sp_reg == SP_W'(2));
                            end_next     = 1'b1;
                            state_next   = ll1ep_pkg::ST_READ;
                        end
                        else
                            state_next = ll1ep_pkg::ST_FINISH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        end_next = (cnt_reg == 2'd3);
                        case (rule.len)
                            2'd0:
                            begin
                                sp_next      = sp_m1;
                                ram_re       = 1'b1;
                                rd_zero_next = (sp_reg == SP_W'(2));
                                state_next   = ll1ep_pkg::ST_READ;
                            end
                            2'd1:
                            begin
                                tos_next   = rule.sym0;
                                state_next = (cnt_reg == 2'd3) ? ll1ep_pkg::ST_FINISH
                                                               : ll1ep_pkg::ST_EVAL;
                            end
                            2'd2:
                            begin
                                tos_next   = rule.sym1;
                                ram_we     = 1'b1;
                                sp_next    = sp_reg + SP_W'(1);
                                state_next = (cnt_reg == 2'd3) ? ll1ep_pkg::ST_FINISH
                                                               : ll1ep_pkg::ST_EVAL;
                            end
                            default:
                            begin
                                tos_next   = rule.sym2;
                                ram_we     = 1'b1;
                                wsym_next  = rule.sym1;
                                waddr_next = sp_reg[ADDR_W-1:0];
                                sp_next    = sp_reg + SP_W'(2);
                                state_next = ll1ep_pkg::ST_WRITE;
                            end
                        endcase
                    end
                end
            end

            ll1ep_pkg::ST_READ:
            begin
                // bottom entry is always the end marker and never stored
                tos_next   = rd_zero_reg ? ll1ep_pkg::SYM_END : ram_rdata;
                state_next = end_reg ? ll1ep_pkg::ST_FINISH : ll1ep_pkg::ST_EVAL;
            end

            ll1ep_pkg::ST_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = waddr_reg;
                ram_wdata  = wsym_reg;
                state_next = end_reg ? ll1ep_pkg::ST_FINISH : ll1ep_pkg::ST_EVAL;
            end

            ll1ep_pkg::ST_FINISH:
            begin
                if (eos_reg)
                begin
                    sp_next   = SP_W'(2);
                    tos_next  = ll1ep_pkg::SYM_E;
                    done_next = 1'b0;
                end
                state_next = ll1ep_pkg::ST_IDLE;
            end

            default: state_next = ll1ep_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_tcls_reg, out_prod_reg, out_ev_reg};
    assign m_tlast  = out_last_reg;

    // Stack pointer never passes the stack depth
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // No further result word for the same input once the final one is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_last_next |=> state_reg != ll1ep_pkg::ST_EVAL)
        else $error("result produced after final word");

    // An end word dropped while done restarts the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && done_reg
        |=> sp_reg == SP_W'(2) && tos_reg == ll1ep_pkg::SYM_E && !done_reg)
        else $error("stack not restarted by end word");

endmodule
